### sv/srt_pkg.sv
// Shared types and constants for the sorted record table.
package srt_pkg;

  localparam int KEY_NAME_W  = 64;
  localparam int KEY_VOL_W   = 16;
  localparam int KEY_PRICE_W = 32;
  localparam int POS_W       = 5;
  localparam int OUT_CNT_W   = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                   mode;
    logic [KEY_NAME_W-1:0]   key_name;
    logic [KEY_VOL_W-1:0]    key_volume;
    logic [KEY_PRICE_W-1:0]  key_price;
    logic [POS_W-1:0]        position;
  } in_req_t;

  typedef struct packed {
    logic                    ok;
    logic [KEY_NAME_W-1:0]   entry_name;
    logic [KEY_VOL_W-1:0]    entry_volume;
    logic [KEY_PRICE_W-1:0]  entry_price;
    logic [OUT_CNT_W-1:0]    entry_count;
    logic                    is_empty;
    logic                    is_full;
  } result_t;

  typedef struct packed {
    logic capture;
    logic apply;
  } ctl_cmd_t;

endpackage

### sv/srt_ctrl.sv
// Request sequencer for the sorted record table: capture, apply, result strobe.
module srt_ctrl import srt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ctl_cmd_t cmd,
  output logic     out_valid
);

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   done_r;
  logic   done_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    done_nxt = cmd.apply;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy      = (state_r == ST_APPLY);
  assign out_valid = done_r;

endmodule

### sv/srt_datapath.sv
// Record cells, per-cell key compare and shift, fill count and result register.
module srt_datapath import srt_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int NAME_BYTES = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ctl_cmd_t cmd,
  input  in_req_t  in_req,
  output result_t  out_res
);

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [NAME_W-1:0]      name_r  [CAPACITY];
  logic [KEY_VOL_W-1:0]   vol_r   [CAPACITY];
  logic [KEY_PRICE_W-1:0] price_r [CAPACITY];

  logic [NAME_W-1:0]      up_name  [CAPACITY];
  logic [KEY_VOL_W-1:0]   up_vol   [CAPACITY];
  logic [KEY_PRICE_W-1:0] up_price [CAPACITY];
  logic [NAME_W-1:0]      dn_name  [CAPACITY];
  logic [KEY_VOL_W-1:0]   dn_vol   [CAPACITY];
  logic [KEY_PRICE_W-1:0] dn_price [CAPACITY];

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  mode_t                  mode_r;
  logic [NAME_W-1:0]      key_name_r;
  logic [KEY_VOL_W-1:0]   key_vol_r;
  logic [KEY_PRICE_W-1:0] key_price_r;
  logic [POS_W-1:0]       pos_r;

  logic [CAPACITY-1:0]    valid;
  logic [CAPACITY-1:0]    ins_ge_c;
  logic [CAPACITY-1:0]    rem_ge_c;
  logic [CAPACITY-1:0]    match_c;
  logic [CAPACITY-1:0]    dup_c;
  logic [CAPACITY-1:0]    ins_ge_r;
  logic [CAPACITY-1:0]    rem_ge_r;
  logic [CAPACITY-1:0]    ins_prev;
  logic                   hit_r;
  logic                   dup_r;

  logic [NAME_W-1:0]      key_name_in;
  logic                   eq;
  logic                   nlt;
  logic                   key_first;

  logic                   full;
  logic                   ins_ok;
  logic                   rem_ok;
  logic                   rd_ok;
  logic [CMP_W-1:0]       pos_w;
  logic [CMP_W-1:0]       cnt_w;
  logic [CMP_W-1:0]       pos_m1;
  logic [IDX_W-1:0]       rd_idx;

  result_t                res_r;
  result_t                res_nxt;

  assign key_name_in = in_req.key_name[NAME_W-1:0];

  // per-cell compare against the incoming key
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      valid[k]    = (CNT_W'(k) < count_r);
      eq          = (name_r[k] == key_name_in);
      nlt         = (name_r[k] < key_name_in);
      key_first   = eq ? (in_req.key_volume < vol_r[k]) : !nlt;
      ins_ge_c[k] = (valid[k] && key_first) || !valid[k];
      rem_ge_c[k] = valid[k] && !nlt;
      match_c[k]  = valid[k] && eq;
      dup_c[k]    = match_c[k] && (vol_r[k] == in_req.key_volume);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r      <= in_req.mode;
      key_name_r  <= key_name_in;
      key_vol_r   <= in_req.key_volume;
      key_price_r <= in_req.key_price;
      pos_r       <= in_req.position;
      ins_ge_r    <= ins_ge_c;
      rem_ge_r    <= rem_ge_c;
      hit_r       <= |match_c;
      dup_r       <= |dup_c;
    end
  end

  assign ins_prev = {ins_ge_r[CAPACITY-2:0], 1'b0};

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign ins_ok = (mode_r == MODE_INSERT) && !full && !dup_r;
  assign rem_ok = (mode_r == MODE_REMOVE) && hit_r;
  assign pos_w  = CMP_W'(pos_r);
  assign cnt_w  = CMP_W'(count_r);
  assign pos_m1 = pos_w - CMP_W'(1);
  assign rd_idx = pos_m1[IDX_W-1:0];
  assign rd_ok  = (mode_r == MODE_READ) && (pos_w != '0) && (pos_w <= cnt_w);

  always_comb begin
    count_nxt           = count_r;
    res_nxt             = '0;
    case (mode_r)
      MODE_INSERT: begin
        res_nxt.ok = ins_ok;
        if (ins_ok) count_nxt = count_r + CNT_W'(1);
      end
      MODE_REMOVE: begin
        res_nxt.ok = rem_ok;
        if (rem_ok) count_nxt = count_r - CNT_W'(1);
      end
      MODE_READ: begin
        res_nxt.ok = rd_ok;
        if (rd_ok) begin
          res_nxt.entry_name   = KEY_NAME_W'(name_r[rd_idx]);
          res_nxt.entry_volume = vol_r[rd_idx];
          res_nxt.entry_price  = price_r[rd_idx];
        end
      end
      MODE_CLEAR: begin
        res_nxt.ok = 1'b1;
        count_nxt  = '0;
      end
      default: res_nxt.ok = 1'b0;
    endcase
    res_nxt.entry_count = OUT_CNT_W'(count_nxt);
    res_nxt.is_empty    = (count_nxt == '0);
    res_nxt.is_full     = (count_nxt == CNT_W'(CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_r <= res_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      if (k == 0) begin : g_first
        assign up_name[k]  = key_name_r;
        assign up_vol[k]   = key_vol_r;
        assign up_price[k] = key_price_r;
      end else begin : g_up
        assign up_name[k]  = name_r[k-1];
        assign up_vol[k]   = vol_r[k-1];
        assign up_price[k] = price_r[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
        assign dn_name[k]  = name_r[k];
        assign dn_vol[k]   = vol_r[k];
        assign dn_price[k] = price_r[k];
      end else begin : g_dn
        assign dn_name[k]  = name_r[k+1];
        assign dn_vol[k]   = vol_r[k+1];
        assign dn_price[k] = price_r[k+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          if (ins_ok) begin
            if (ins_ge_r[k] && !ins_prev[k]) begin
              name_r[k]  <= key_name_r;
              vol_r[k]   <= key_vol_r;
              price_r[k] <= key_price_r;
            end else if (ins_prev[k]) begin
              name_r[k]  <= up_name[k];
              vol_r[k]   <= up_vol[k];
              price_r[k] <= up_price[k];
            end
          end else if (rem_ok && rem_ge_r[k]) begin
            name_r[k]  <= dn_name[k];
            vol_r[k]   <= dn_vol[k];
            price_r[k] <= dn_price[k];
          end
        end
      end
    end
  endgenerate

  assign out_res = res_r;

endmodule

### sv/sorted_record_table_top.sv
// Sorted record table: up to CAPACITY records ordered by name, then volume.
// A request is latched at capture; its result and strobe are registered on apply.
// A new request is taken only when idle; busy is high for the one apply cycle, in which
// every cell shifts in parallel, on compare results registered at capture.
// Reset (rst_n low, synchronous) empties the table and drops any pending result strobe.
// Results are shown for one cycle only; the receiver cannot stall them.
module sorted_record_table_top import srt_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int NAME_BYTES = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  in_req_t in_req,
  output logic    out_valid,
  output result_t out_res
);

  ctl_cmd_t cmd;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  srt_datapath #(
    .CAPACITY   (CAPACITY),
    .NAME_BYTES (NAME_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_res (out_res)
  );

endmodule
